### sv/spcp_pkg.sv
// Package for the sub-cell pair picker: widths, list-unit request types and state codes.
// Used by spcp_remover and subcell_pair_picker_no_repeat; depends on nothing.
`default_nettype none
package spcp_pkg;

  localparam int MAX_PARTICLES = 256;
  localparam int SUB_CELLS     = 8;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int OCT_W         = $clog2(SUB_CELLS);
  localparam int SUB_AW        = OCT_W + IDX_W;
  localparam int RAND_W        = 16;
  localparam int OUT_IDX_W     = 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [OCT_W-1:0] oct_t;

  // Command to the list removal unit
  typedef struct packed {
    logic start;
    logic by_pos;   // 1: remove at position key, 0: remove entry equal to key
    logic sel_sub;  // 1: sub-cell list oct, 0: cell list
    oct_t oct;
    idx_t key;
    cnt_t count;
  } rm_cmd_t;

  // Memory access issued by the removal unit
  typedef struct packed {
    logic sel_sub;
    oct_t oct;
    idx_t rd_idx;
    logic we;
    idx_t wr_idx;
    idx_t wr_data;
  } rm_mem_t;

  typedef struct packed {
    logic done;
    logic found;
    idx_t picked;
  } rm_rsp_t;

  typedef enum logic [1:0] {
    RM_IDLE,
    RM_RD,
    RM_CHK
  } rm_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P_IDX,
    S_P_RM,
    S_P_OCT,
    S_P_OCTW,
    S_SUB1,
    S_CHOOSE,
    S_Q1,
    S_Q_CELL,
    S_Q2,
    S_Q_OCT,
    S_Q_OCTW,
    S_Q3,
    S_OUT
  } state_t;

  // Map a random word onto a list of n entries: (r*n)>>16
  function automatic idx_t scale_idx(input logic [RAND_W-1:0] r, input cnt_t n);
    logic [RAND_W+CNT_W-1:0] prod;
    prod = (RAND_W+CNT_W)'(r) * (RAND_W+CNT_W)'(n);
    return idx_t'(prod >> RAND_W);
  endfunction

  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input idx_t p);
    logic [IDX_W+OUT_IDX_W-1:0] w;
    w = {{OUT_IDX_W{1'b0}}, p};
    return w[OUT_IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

### sv/subcell_pair_picker_no_repeat.sv
// A load request gives no result. A draw request walks its lists through the shared
// removal unit one list entry at a time (an empty cell goes straight to the result),
// and its result also waits for the result register to empty.
// One request at a time; ready is held low while a draw is in progress.
// Reset (rst_n low, synchronous) empties all lists by clearing the counts;
// list memories are not cleared.
`default_nettype none
module subcell_pair_picker_no_repeat (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // rel_x[31:0], rel_y[63:32], rel_z[95:64], rand_first[111:96],
  // rand_second[127:112], rand_third[143:128]
  input  wire logic [143:0] in_tdata,
  // func[0], first_of_cell[1]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pair_found[0], first_valid[1], first_particle[9:2], second_particle[17:10],
  // partner_same_sub_cell[18], zero[23:19]
  output logic [23:0]       out_tdata
);

  localparam spcp_pkg::cnt_t MAXC = spcp_pkg::CNT_W'(spcp_pkg::MAX_PARTICLES);

  spcp_pkg::state_t  state_r, state_nxt;
  spcp_pkg::cnt_t    cell_cnt_r, cell_cnt_nxt;
  spcp_pkg::cnt_t    loaded_r, loaded_nxt;
  spcp_pkg::cnt_t    sub_cnt_r [spcp_pkg::SUB_CELLS];
  spcp_pkg::cnt_t    sub_cnt_nxt [spcp_pkg::SUB_CELLS];
  logic [15:0]       rf_r, rf_nxt, rs_r, rs_nxt, rt_r, rt_nxt;
  spcp_pkg::idx_t    p_r, p_nxt, q_r, q_nxt;
  spcp_pkg::oct_t    s_r, s_nxt;
  logic              same_r, same_nxt, found_r, found_nxt, fv_r, fv_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [23:0]       out_data_r, out_data_nxt;

  spcp_pkg::rm_cmd_t cmd;
  spcp_pkg::rm_mem_t mem;
  spcp_pkg::rm_rsp_t rsp;
  spcp_pkg::idx_t    cell_rd, sub_rd, u_rd;
  spcp_pkg::oct_t    oct_rd;

  logic              in_acc, ld, ld_ok, cell_ok, sub_ok, first;
  spcp_pkg::oct_t    ld_oct;
  spcp_pkg::cnt_t    eff_loaded, eff_cell, eff_sub;

  logic                      cell_we, sub_we;
  spcp_pkg::idx_t            cell_wa;
  spcp_pkg::idx_t            cell_wd, sub_wd;
  logic [spcp_pkg::SUB_AW-1:0] sub_wa;

  assign in_tready  = (state_r == spcp_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // load request decode
  always_comb begin
    in_acc     = in_tvalid && in_tready;
    first      = in_tuser[1];
    ld         = in_acc && !in_tuser[0];
    ld_oct     = {~in_tdata[95], ~in_tdata[63], ~in_tdata[31]};
    eff_loaded = first ? '0 : loaded_r;
    eff_cell   = first ? '0 : cell_cnt_r;
    eff_sub    = first ? '0 : sub_cnt_r[ld_oct];
    ld_ok      = ld && (eff_loaded < MAXC);
    cell_ok    = ld_ok && (eff_cell < MAXC);
    sub_ok     = ld_ok && (eff_sub < MAXC);
  end

  // memory port selection: loads in idle, removal unit otherwise
  always_comb begin
    cell_we = cell_ok || (mem.we && !mem.sel_sub);
    cell_wa = cell_ok ? spcp_pkg::IDX_W'(eff_cell) : mem.wr_idx;
    cell_wd = cell_ok ? spcp_pkg::IDX_W'(eff_loaded) : mem.wr_data;
    sub_we  = sub_ok || (mem.we && mem.sel_sub);
    sub_wa  = sub_ok ? {ld_oct, spcp_pkg::IDX_W'(eff_sub)} : {mem.oct, mem.wr_idx};
    sub_wd  = sub_ok ? spcp_pkg::IDX_W'(eff_loaded) : mem.wr_data;
    u_rd    = mem.sel_sub ? sub_rd : cell_rd;
  end

  spcp_ram #(.WIDTH(spcp_pkg::IDX_W), .DEPTH(spcp_pkg::MAX_PARTICLES)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_wa),
    .wdata (cell_wd),
    .raddr (mem.rd_idx),
    .rdata (cell_rd)
  );

  spcp_ram #(.WIDTH(spcp_pkg::IDX_W),
             .DEPTH(spcp_pkg::SUB_CELLS * spcp_pkg::MAX_PARTICLES)) u_sub_ram (
    .clk   (clk),
    .we    (sub_we),
    .waddr (sub_wa),
    .wdata (sub_wd),
    .raddr ({mem.oct, mem.rd_idx}),
    .rdata (sub_rd)
  );

  spcp_ram #(.WIDTH(spcp_pkg::OCT_W), .DEPTH(spcp_pkg::MAX_PARTICLES)) u_oct_ram (
    .clk   (clk),
    .we    (ld_ok),
    .waddr (spcp_pkg::IDX_W'(eff_loaded)),
    .wdata (ld_oct),
    .raddr ((state_r == spcp_pkg::S_P_OCT) ? p_r : q_r),
    .rdata (oct_rd)
  );

  spcp_remover u_remover (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_data (u_rd),
    .mem     (mem),
    .rsp     (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spcp_pkg::S_IDLE;
      cell_cnt_r  <= '0;
      loaded_r    <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < spcp_pkg::SUB_CELLS; k++) begin
        sub_cnt_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cell_cnt_r  <= cell_cnt_nxt;
      loaded_r    <= loaded_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < spcp_pkg::SUB_CELLS; k++) begin
        sub_cnt_r[k] <= sub_cnt_nxt[k];
      end
    end
    rf_r       <= rf_nxt;
    rs_r       <= rs_nxt;
    rt_r       <= rt_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    s_r        <= s_nxt;
    same_r     <= same_nxt;
    found_r    <= found_nxt;
    fv_r       <= fv_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cell_cnt_nxt  = cell_cnt_r;
    loaded_nxt    = loaded_r;
    for (int k = 0; k < spcp_pkg::SUB_CELLS; k++) begin
      sub_cnt_nxt[k] = sub_cnt_r[k];
    end
    rf_nxt        = rf_r;
    rs_nxt        = rs_r;
    rt_nxt        = rt_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    s_nxt         = s_r;
    same_nxt      = same_r;
    found_nxt     = found_r;
    fv_nxt        = fv_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;

    unique case (state_r)
      spcp_pkg::S_IDLE: begin
        if (ld) begin
          if (first) begin
            for (int k = 0; k < spcp_pkg::SUB_CELLS; k++) begin
              sub_cnt_nxt[k] = '0;
            end
          end
          cell_cnt_nxt = eff_cell;
          loaded_nxt   = eff_loaded;
          if (ld_ok) begin
            loaded_nxt = eff_loaded + spcp_pkg::CNT_W'(1);
          end
          if (cell_ok) begin
            cell_cnt_nxt = eff_cell + spcp_pkg::CNT_W'(1);
          end
          if (sub_ok) begin
            sub_cnt_nxt[ld_oct] = eff_sub + spcp_pkg::CNT_W'(1);
          end
        end else if (in_acc) begin
          rf_nxt    = in_tdata[111:96];
          rs_nxt    = in_tdata[127:112];
          rt_nxt    = in_tdata[143:128];
          same_nxt  = 1'b0;
          found_nxt = 1'b0;
          fv_nxt    = 1'b0;
          p_nxt     = '0;
          q_nxt     = '0;
          state_nxt = spcp_pkg::S_P_IDX;
        end
      end
      spcp_pkg::S_P_IDX: begin
        if (cell_cnt_r == '0) begin
          state_nxt = spcp_pkg::S_OUT;
        end else begin
          cmd.start  = 1'b1;
          cmd.by_pos = 1'b1;
          cmd.key    = spcp_pkg::scale_idx(rf_r, cell_cnt_r);
          cmd.count  = cell_cnt_r;
          state_nxt  = spcp_pkg::S_P_RM;
        end
      end
      spcp_pkg::S_P_RM: begin
        if (rsp.done) begin
          p_nxt        = rsp.picked;
          fv_nxt       = 1'b1;
          cell_cnt_nxt = cell_cnt_r - spcp_pkg::CNT_W'(1);
          state_nxt    = spcp_pkg::S_P_OCT;
        end
      end
      spcp_pkg::S_P_OCT: begin
        state_nxt = spcp_pkg::S_P_OCTW;
      end
      spcp_pkg::S_P_OCTW: begin
        s_nxt       = oct_rd;
        cmd.start   = 1'b1;
        cmd.sel_sub = 1'b1;
        cmd.oct     = oct_rd;
        cmd.key     = p_r;
        cmd.count   = sub_cnt_r[oct_rd];
        state_nxt   = spcp_pkg::S_SUB1;
      end
      spcp_pkg::S_SUB1: begin
        if (rsp.done) begin
          if (rsp.found) begin
            sub_cnt_nxt[s_r] = sub_cnt_r[s_r] - spcp_pkg::CNT_W'(1);
          end
          state_nxt = spcp_pkg::S_CHOOSE;
        end
      end
      spcp_pkg::S_CHOOSE: begin
        // prefer a partner from the same sub-cell, fall back to the whole cell
        if (sub_cnt_r[s_r] != '0) begin
          cmd.start   = 1'b1;
          cmd.by_pos  = 1'b1;
          cmd.sel_sub = 1'b1;
          cmd.oct     = s_r;
          cmd.key     = spcp_pkg::scale_idx(rs_r, sub_cnt_r[s_r]);
          cmd.count   = sub_cnt_r[s_r];
          same_nxt    = 1'b1;
          state_nxt   = spcp_pkg::S_Q1;
        end else if (cell_cnt_r != '0) begin
          cmd.start  = 1'b1;
          cmd.by_pos = 1'b1;
          cmd.key    = spcp_pkg::scale_idx(rt_r, cell_cnt_r);
          cmd.count  = cell_cnt_r;
          state_nxt  = spcp_pkg::S_Q1;
        end else begin
          state_nxt = spcp_pkg::S_OUT;
        end
      end
      spcp_pkg::S_Q1: begin
        if (rsp.done) begin
          q_nxt = rsp.picked;
          if (same_r) begin
            sub_cnt_nxt[s_r] = sub_cnt_r[s_r] - spcp_pkg::CNT_W'(1);
            state_nxt        = spcp_pkg::S_Q_CELL;
          end else begin
            cell_cnt_nxt = cell_cnt_r - spcp_pkg::CNT_W'(1);
            state_nxt    = spcp_pkg::S_Q_OCT;
          end
        end
      end
      spcp_pkg::S_Q_CELL: begin
        // removal unit is idle again: drop the partner from the cell list
        cmd.start = 1'b1;
        cmd.key   = q_r;
        cmd.count = cell_cnt_r;
        state_nxt = spcp_pkg::S_Q2;
      end
      spcp_pkg::S_Q2: begin
        if (rsp.done) begin
          if (rsp.found) begin
            cell_cnt_nxt = cell_cnt_r - spcp_pkg::CNT_W'(1);
          end
          found_nxt = 1'b1;
          state_nxt = spcp_pkg::S_OUT;
        end
      end
      spcp_pkg::S_Q_OCT: begin
        state_nxt = spcp_pkg::S_Q_OCTW;
      end
      spcp_pkg::S_Q_OCTW: begin
        s_nxt       = oct_rd;
        cmd.start   = 1'b1;
        cmd.sel_sub = 1'b1;
        cmd.oct     = oct_rd;
        cmd.key     = q_r;
        cmd.count   = sub_cnt_r[oct_rd];
        state_nxt   = spcp_pkg::S_Q3;
      end
      spcp_pkg::S_Q3: begin
        if (rsp.done) begin
          if (rsp.found) begin
            sub_cnt_nxt[s_r] = sub_cnt_r[s_r] - spcp_pkg::CNT_W'(1);
          end
          found_nxt = 1'b1;
          state_nxt = spcp_pkg::S_OUT;
        end
      end
      spcp_pkg::S_OUT: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, same_r && found_r,
                           found_r ? spcp_pkg::to_out_idx(q_r) : 8'd0,
                           fv_r ? spcp_pkg::to_out_idx(p_r) : 8'd0,
                           fv_r, found_r};
          state_nxt     = spcp_pkg::S_IDLE;
        end
      end
      default: state_nxt = spcp_pkg::S_IDLE;
    endcase
  end

  a_cell_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cell_cnt_r <= loaded_r && loaded_r <= MAXC)
    else $error("cell count exceeds loaded count");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == spcp_pkg::S_P_RM || state_r == spcp_pkg::S_SUB1 ||
                  state_r == spcp_pkg::S_Q1 || state_r == spcp_pkg::S_Q2 ||
                  state_r == spcp_pkg::S_Q3))
    else $error("removal finished while sequencer not waiting");

  a_no_pair_without_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[1] |-> out_data_r[0] == 1'b0 && out_data_r[9:2] == 8'd0)
    else $error("pair reported without first particle");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser[0]) |=> state_r == spcp_pkg::S_IDLE)
    else $error("load left idle");

endmodule
`default_nettype wire

### sv/spcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none
module spcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/spcp_remover.sv
// Shared list removal unit: walks a list one entry at a time, finds the entry
// by position or by value and shifts the rest down one place. Depends on spcp_pkg.
`default_nettype none
module spcp_remover (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire spcp_pkg::rm_cmd_t cmd,
  input  wire spcp_pkg::idx_t   rd_data,
  output spcp_pkg::rm_mem_t     mem,
  output spcp_pkg::rm_rsp_t     rsp
);

  spcp_pkg::rm_state_t st_r, st_nxt;
  logic                by_pos_r, by_pos_nxt;
  logic                sel_r, sel_nxt;
  spcp_pkg::oct_t      oct_r, oct_nxt;
  spcp_pkg::idx_t      key_r, key_nxt;
  spcp_pkg::cnt_t      count_r, count_nxt;
  spcp_pkg::cnt_t      i_r, i_nxt;
  logic                shift_r, shift_nxt;
  spcp_pkg::idx_t      picked_r, picked_nxt;
  logic                match;
  logic                last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= spcp_pkg::RM_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    by_pos_r <= by_pos_nxt;
    sel_r    <= sel_nxt;
    oct_r    <= oct_nxt;
    key_r    <= key_nxt;
    count_r  <= count_nxt;
    i_r      <= i_nxt;
    shift_r  <= shift_nxt;
    picked_r <= picked_nxt;
  end

  always_comb begin
    match = (st_r == spcp_pkg::RM_CHK) && !shift_r &&
            (by_pos_r ? (i_r == {1'b0, key_r}) : (rd_data == key_r));
    last  = (i_r == count_r - spcp_pkg::CNT_W'(1));

    mem.sel_sub = sel_r;
    mem.oct     = oct_r;
    mem.rd_idx  = i_r[spcp_pkg::IDX_W-1:0];
    mem.we      = (st_r == spcp_pkg::RM_CHK) && shift_r;
    mem.wr_idx  = spcp_pkg::IDX_W'(i_r - spcp_pkg::CNT_W'(1));
    mem.wr_data = rd_data;

    rsp.done   = (st_r == spcp_pkg::RM_CHK) && last;
    rsp.found  = shift_r || match;
    rsp.picked = match ? rd_data : picked_r;

    st_nxt     = st_r;
    by_pos_nxt = by_pos_r;
    sel_nxt    = sel_r;
    oct_nxt    = oct_r;
    key_nxt    = key_r;
    count_nxt  = count_r;
    i_nxt      = i_r;
    shift_nxt  = shift_r;
    picked_nxt = picked_r;

    unique case (st_r)
      spcp_pkg::RM_IDLE: begin
        if (cmd.start) begin
          by_pos_nxt = cmd.by_pos;
          sel_nxt    = cmd.sel_sub;
          oct_nxt    = cmd.oct;
          key_nxt    = cmd.key;
          count_nxt  = cmd.count;
          i_nxt      = cmd.by_pos ? {1'b0, cmd.key} : '0;
          shift_nxt  = 1'b0;
          st_nxt     = spcp_pkg::RM_RD;
        end
      end
      spcp_pkg::RM_RD: begin
        st_nxt = spcp_pkg::RM_CHK;
      end
      spcp_pkg::RM_CHK: begin
        // from the match onwards, each entry moves down one place
        if (match) begin
          shift_nxt  = 1'b1;
          picked_nxt = rd_data;
        end
        if (last) begin
          st_nxt = spcp_pkg::RM_IDLE;
        end else begin
          i_nxt  = i_r + spcp_pkg::CNT_W'(1);
          st_nxt = spcp_pkg::RM_RD;
        end
      end
      default: st_nxt = spcp_pkg::RM_IDLE;
    endcase
  end

endmodule
`default_nettype wire
